@@ design/lcgrr_pkg.sv @@
// ----------------------------------------------------------------------------
// lcgrr_pkg
// Shared types and constants for the range-limited LCG random generator.
// ----------------------------------------------------------------------------
package lcgrr_pkg;

  localparam int unsigned SEED_W    = 31;
  localparam int unsigned LIMIT_W   = 32;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW   = 1;
  localparam int unsigned CNT_W     = 5;

  localparam logic [31:0]       LCG_MUL    = 32'd1103515245;
  localparam logic [SEED_W-1:0] LCG_ADD    = 31'd12345;
  localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

  // classified request as held in the queue
  typedef struct packed {
    logic [LIMIT_W-1:0] mag;
    logic               is_zero;
  } lcgrr_item_t;

endpackage

@@ design/lcgrr_front.sv @@
// ----------------------------------------------------------------------------
// lcgrr_front
// Accepts range limits, takes the magnitude and flags a zero limit.
// ----------------------------------------------------------------------------
module lcgrr_front import lcgrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [LIMIT_W-1:0] range_limit_i,
  input  logic               full_i,
  output logic               push_o,
  output lcgrr_item_t        push_item_o
);

  logic [LIMIT_W-1:0] mag;

  // magnitude of -2^31 is 2^31, which still fits in 32 unsigned bits
  assign mag = range_limit_i[LIMIT_W-1] ? (~range_limit_i + LIMIT_W'(1)) : range_limit_i;

  assign in_ready_o          = rst_ni & ~full_i;
  assign push_o              = in_valid_i & in_ready_o;
  assign push_item_o.mag     = mag;
  assign push_item_o.is_zero = (range_limit_i == '0);

  logic unused_clk;
  assign unused_clk = clk_i;

endmodule

@@ design/lcgrr_fifo.sv @@
// ----------------------------------------------------------------------------
// lcgrr_fifo
// Two-entry queue between the request front and the compute back.
// ----------------------------------------------------------------------------
module lcgrr_fifo import lcgrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lcgrr_item_t push_item_i,
  input  logic        pop_i,
  output lcgrr_item_t pop_item_o,
  output logic        full_o,
  output logic        empty_o
);

  lcgrr_item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]         count_q, count_d;

  assign full_o     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    count_d  = count_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ design/lcgrr_back.sv @@
// ----------------------------------------------------------------------------
// lcgrr_back
// Advances the seed and reduces it by the limit with a restoring remainder.
// ----------------------------------------------------------------------------
module lcgrr_back import lcgrr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  lcgrr_item_t       pop_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SEED_W-1:0] random_value_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [SEED_W-1:0]  seed_q, seed_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [SEED_W-1:0]  out_value_q, out_value_d;
  logic [SEED_W-1:0]  prod_q, prod_d;
  logic [LIMIT_W-1:0] mag_q, mag_d;
  logic               zero_q, zero_d;
  logic [SEED_W-1:0]  div_q, div_d;
  logic [LIMIT_W-1:0] rem_q, rem_d;
  logic [SEED_W-1:0]  res_q, res_d;

  logic [31:0]        mul_w;
  logic [SEED_W-1:0]  seed_next;
  logic [LIMIT_W-1:0] rem_sh;
  logic [LIMIT_W-1:0] rem_new;
  logic               out_free;

  assign mul_w     = {1'b0, seed_q} * LCG_MUL;
  assign seed_next = prod_q + LCG_ADD;
  assign rem_sh    = {rem_q[LIMIT_W-2:0], div_q[SEED_W-1]};
  assign rem_new   = (rem_sh >= mag_q) ? rem_sh - mag_q : rem_sh;
  assign out_free  = ~out_valid_q | out_ready_i;

  assign pop_o          = (state_q == S_IDLE) & ~empty_i;
  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_value_q;

  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    mag_d       = mag_q;
    zero_d      = zero_q;
    div_d       = div_q;
    rem_d       = rem_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_value_d = out_value_q;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          mag_d   = pop_item_i.mag;
          zero_d  = pop_item_i.is_zero;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = mul_w[SEED_W-1:0];
        state_d = S_ADD;
      end
      S_ADD: begin
        seed_d = seed_next;
        div_d  = seed_next;
        res_d  = seed_next;
        rem_d  = '0;
        cnt_d  = '0;
        state_d = zero_q ? S_DONE : S_DIV;
      end
      S_DIV: begin
        rem_d = rem_new;
        div_d = {div_q[SEED_W-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SEED_W - 1)) begin
          // final remainder is below the magnitude, so it fits in 31 bits
          res_d   = rem_new[SEED_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= SEED_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    mag_q       <= mag_d;
    zero_q      <= zero_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    res_q       <= res_d;
    out_value_q <= out_value_d;
  end

endmodule

@@ design/lcg_random_with_range_top.sv @@
// ----------------------------------------------------------------------------
// lcg_random_with_range_top
// Range-limited 31-bit linear congruential random number generator.
// ----------------------------------------------------------------------------
// Each accepted range limit advances the 31-bit seed (reset value 1) by
// seed = (seed * 1103515245 + 12345) mod 2^31 and returns one word: the new
// seed when the limit is zero, otherwise the seed modulo the limit's
// magnitude. In the compute side a request goes through states that pick it
// up, do the multiply, do the add, run the one-bit-per-cycle restoring
// remainder and load the output register once it is free; a zero limit
// skips the remainder. A two-word request queue lets up to two further
// limits be taken while a request is in work or a result waits to be taken.
module lcg_random_with_range_top import lcgrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [LIMIT_W-1:0] range_limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SEED_W-1:0]  random_value_o
);

  logic        full, empty, push, pop;
  lcgrr_item_t push_item, pop_item;

  lcgrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .range_limit_i(range_limit_i),
    .full_i       (full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  lcgrr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .full_o     (full),
    .empty_o    (empty)
  );

  lcgrr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_item_i    (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_value_o(random_value_o)
  );

endmodule

@@ design/lcgrr_checker.sv @@
// ----------------------------------------------------------------------------
// lcgrr_checker
// Port-level checks for the range-limited LCG generator.
// ----------------------------------------------------------------------------
module lcgrr_checker import lcgrr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [LIMIT_W-1:0] range_limit_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [SEED_W-1:0]  random_value_o
);

  // words taken in but not yet delivered
  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(random_value_o))
    else $error("result dropped or changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more requests in flight than storage allows");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd4 |-> !in_ready_o)
    else $error("request accepted with no room left");

  logic unused_limit;
  assign unused_limit = ^range_limit_i;

endmodule

bind lcg_random_with_range_top lcgrr_checker u_lcgrr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .range_limit_i (range_limit_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .random_value_o(random_value_o)
);
